[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the sorted task queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define STQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define STQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define STQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define STQ_ASSERT(lbl, clk, rst_n, prop)
`define STQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/stq_pkg.sv]
// Types, codes and helpers for the sorted task queue.
package stq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int OP_W      = 3;
  localparam int TASK_W    = 4;
  localparam int KEY_W     = 32;
  localparam int STAT_W    = 2;

  localparam logic [OP_W-1:0] OP_INS_SORTED = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
  localparam logic [OP_W-1:0] OP_POP        = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // one queue slot
  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] task_num;
    logic [KEY_W-1:0]  value;
  } slot_t;

  // per-beat command broadcast to every cell
  typedef struct packed {
    logic              do_ins;
    logic              sorted;
    logic              do_rem;
    logic              wrap_mode;
    logic [TASK_W-1:0] task_num;
    logic [KEY_W-1:0]  key;
  } cell_cmd_t;

  // handed from each cell to its right neighbor
  typedef struct packed {
    logic shift;  // an insert happened further left: take left data
    logic pull;   // a removal happened at or left of here: take right data
  } chain_t;

  // true when key a orders strictly before key b
  function automatic logic key_before(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic wrap);
    logic [KEY_W-1:0] diff;
    diff = a - b;
    return wrap ? diff[KEY_W-1] : (a < b);
  endfunction

endpackage

[hw/rtl/stq_if.sv]
// Valid/ready channel interfaces for the sorted task queue.
interface stq_in_if;
  logic                        valid;
  logic                        ready;
  logic [stq_pkg::OP_W-1:0]    opcode;
  logic [stq_pkg::TASK_W-1:0]  task_number;
  logic [stq_pkg::KEY_W-1:0]   sort_value;

  modport source (output valid, opcode, task_number, sort_value, input ready);
  modport sink   (input valid, opcode, task_number, sort_value, output ready);
endinterface

interface stq_out_if;
  logic                        valid;
  logic                        ready;
  logic [stq_pkg::STAT_W-1:0]  status;
  logic [stq_pkg::TASK_W-1:0]  head_task;
  logic [stq_pkg::KEY_W-1:0]   head_value;
  logic [stq_pkg::CNT_W-1:0]   entry_count;

  modport source (output valid, status, head_task, head_value, entry_count, input ready);
  modport sink   (input valid, status, head_task, head_value, entry_count, output ready);
endinterface

[hw/rtl/stq_cell.sv]
// One slot of the queue: compare, insert, and shift left or right.
module stq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::cell_cmd_t cmd,
  input  stq_pkg::chain_t    chain_in,
  output stq_pkg::chain_t    chain_out,
  input  stq_pkg::slot_t     left_slot,
  input  stq_pkg::slot_t     right_slot,
  output stq_pkg::slot_t     slot_o
);

  logic                       valid_r, valid_nxt;
  logic [stq_pkg::TASK_W-1:0] task_r, task_nxt;
  logic [stq_pkg::KEY_W-1:0]  value_r, value_nxt;
  logic                       hit, ins_here, rem_here, load;

  always_comb begin
    hit      = cmd.do_ins & cmd.sorted & valid_r &
               stq_pkg::key_before(cmd.key, value_r, cmd.wrap_mode);
    // first slot whose key orders after the new one, else first empty slot
    ins_here = cmd.do_ins & ~chain_in.shift & (hit | ~valid_r);
    rem_here = cmd.do_rem & ~chain_in.pull & valid_r & (task_r == cmd.task_num);
    chain_out.shift = chain_in.shift | ins_here;
    chain_out.pull  = chain_in.pull | rem_here;

    valid_nxt = valid_r;
    task_nxt  = task_r;
    value_nxt = value_r;
    load      = 1'b0;
    if (chain_in.shift) begin
      valid_nxt = left_slot.valid;
      task_nxt  = left_slot.task_num;
      value_nxt = left_slot.value;
      load      = 1'b1;
    end else if (ins_here) begin
      valid_nxt = 1'b1;
      task_nxt  = cmd.task_num;
      value_nxt = cmd.key;
      load      = 1'b1;
    end else if (chain_out.pull) begin
      valid_nxt = right_slot.valid;
      task_nxt  = right_slot.task_num;
      value_nxt = right_slot.value;
      load      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      task_r  <= task_nxt;
      value_r <= value_nxt;
    end
  end

  assign slot_o = '{valid: valid_r, task_num: task_r, value: value_r};

endmodule

[hw/rtl/sorted_task_queue.sv]
// Top level of the sorted task queue: cell row, counter and result register.
// Usage
//   in_ch  : one beat per operation (opcode, task_number, sort_value).
//            Opcodes: sorted insert, tail insert, remove task, pop, peek.
//   out_ch : one result beat per operation, in order
//            (status, head_task, head_value, entry_count).
//   cfg_we/cfg_wdata : key_compare_mode, 0 unsigned, 1 wraparound by signed
//            difference. Write only while the queue is idle.
// Timing
//   The queue is a row of MAX_TASKS cells. Each cell compares its key with
//   the broadcast key and moves its entry left or right in the same cycle,
//   so every operation completes in the cycle it is accepted.
//   The result is registered and valid in the cycle after the beat is taken.
//   One op per cycle unless out_ch stalls; the insert chain crosses the row.
// Reset
//   Synchronous, active low: queue empty, compare mode unsigned, no result
//   pending. Entry payloads are not cleared; empty cells are never read.
// Backpressure
//   The result register is one deep. While out_ch stalls and holds a
//   result, in_ch.ready drops; the beat is taken as soon as the result goes.
`include "assert_macros.svh"

module sorted_task_queue (
  input  logic clk,
  input  logic rst_n,
  stq_in_if.sink    in_ch,
  stq_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int N = stq_pkg::MAX_TASKS;

  // config
  logic mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // handshake
  logic out_valid_r;
  logic in_acc;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_acc      = in_ch.valid & in_ch.ready;

  // decode
  logic [stq_pkg::CNT_W-1:0] count_r, count_nxt;
  logic is_ins, is_rem, is_pop, is_peek, full, empty;
  stq_pkg::cell_cmd_t cmd;

  always_comb begin
    is_ins  = (in_ch.opcode == stq_pkg::OP_INS_SORTED) ||
              (in_ch.opcode == stq_pkg::OP_INS_TAIL);
    is_rem  = (in_ch.opcode == stq_pkg::OP_REMOVE);
    is_pop  = (in_ch.opcode == stq_pkg::OP_POP);
    is_peek = (in_ch.opcode == stq_pkg::OP_PEEK);
    full    = (count_r == stq_pkg::CNT_W'(N));
    empty   = (count_r == '0);

    cmd.do_ins    = in_acc & is_ins & ~full;
    cmd.sorted    = (in_ch.opcode == stq_pkg::OP_INS_SORTED);
    cmd.do_rem    = in_acc & is_rem;
    cmd.wrap_mode = mode_r;
    cmd.task_num  = in_ch.task_number;
    cmd.key       = in_ch.sort_value;
  end

  // cell row; chain[i] enters cell i, slots[i] leaves it
  stq_pkg::chain_t chain [N+1];
  stq_pkg::slot_t  slots [N];
  stq_pkg::slot_t  no_slot;

  assign no_slot     = '0;
  assign chain[0].shift = 1'b0;
  assign chain[0].pull  = in_acc & is_pop & ~empty;  // pop: whole row moves left

  for (genvar i = 0; i < N; i++) begin : g_cell
    stq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .left_slot  ((i == 0) ? no_slot : slots[(i == 0) ? 0 : i-1]),
      .right_slot ((i == N-1) ? no_slot : slots[(i == N-1) ? i : i+1]),
      .slot_o     (slots[i])
    );
  end

  logic rem_found;
  assign rem_found = chain[N].pull;

  // count and result
  logic [stq_pkg::STAT_W-1:0] status_nxt, status_r;
  logic [stq_pkg::TASK_W-1:0] head_task_nxt, head_task_r;
  logic [stq_pkg::KEY_W-1:0]  head_value_nxt, head_value_r;

  always_comb begin
    count_nxt      = count_r;
    status_nxt     = stq_pkg::ST_OK;
    head_task_nxt  = '0;
    head_value_nxt = '0;
    if (is_ins) begin
      if (full) begin
        status_nxt = stq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (is_rem) begin
      if (rem_found) begin
        count_nxt = count_r - 1'b1;
      end else begin
        status_nxt = stq_pkg::ST_NOT_FOUND;
      end
    end else if (is_pop || is_peek) begin
      if (empty) begin
        status_nxt = stq_pkg::ST_EMPTY;
      end else begin
        head_task_nxt  = slots[0].task_num;
        head_value_nxt = slots[0].value;
        if (is_pop) begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  logic [stq_pkg::CNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r     <= status_nxt;
      head_task_r  <= head_task_nxt;
      head_value_r <= head_value_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.head_task   = head_task_r;
  assign out_ch.head_value  = head_value_r;
  assign out_ch.entry_count = out_count_r;

  // checks
  logic [N-1:0] valid_vec;
  for (genvar i = 0; i < N; i++) begin : g_vld
    assign valid_vec[i] = slots[i].valid;
  end

  `STQ_ASSERT(a_count_max, clk, rst_n, count_r <= stq_pkg::CNT_W'(N))
  `STQ_ASSERT(a_valid_matches_count, clk, rst_n,
    $countones(valid_vec) == 32'(count_r))
  `STQ_ASSERT_IMP(a_valid_prefix, clk, rst_n, count_r != '0, slots[0].valid)
  `STQ_ASSERT_NXT(a_pop_decrements, clk, rst_n,
    in_acc && is_pop && !empty, count_r == $past(count_r) - 1'b1)
  `STQ_ASSERT_NXT(a_result_follows, clk, rst_n, in_acc, out_valid_r)

endmodule

[sim/sorted_task_queue_test.sv]
// Self-checking testbench for sorted_task_queue: random and directed opcodes, shadow queue.
module sorted_task_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcodes 5..7 decode to nothing; the block must still answer each one.
  localparam logic [stq_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [stq_pkg::OP_W-1:0] OP_SPARE_HI = {stq_pkg::OP_W{1'b1}};

  localparam logic [stq_pkg::KEY_W-1:0] KEY_MAX      = {stq_pkg::KEY_W{1'b1}};
  localparam logic [stq_pkg::KEY_W-1:0] KEY_SIGN_BIT = {1'b1, {(stq_pkg::KEY_W-1){1'b0}}};

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_WRAP     = 1'b1;

  // Random beats per stretch; six stretches make up about 1400 beats.
  localparam int BEATS_PER_STRETCH = 230;
  // Cycles without any handshake on either channel before giving up.
  localparam int STALL_LIMIT = 2000;
  // Cycles left to run once nothing is outstanding.
  localparam int TAIL_CYCLES = 4;

  typedef struct {
    logic [stq_pkg::TASK_W-1:0] task_num;
    logic [stq_pkg::KEY_W-1:0]  key;
  } queued_task_t;

  typedef struct {
    logic [stq_pkg::STAT_W-1:0] status;
    logic [stq_pkg::TASK_W-1:0] head_task;
    logic [stq_pkg::KEY_W-1:0]  head_value;
    logic [stq_pkg::CNT_W-1:0]  entry_count;
  } queue_reply_t;

  // Shadow of the queue contents plus the replies still owed by the block.
  class sorted_queue_checker;
    queued_task_t shadow[$];
    queue_reply_t awaited[$];
    logic         wrap_mode;
    int           errors;

    function new();
      wrap_mode = MODE_UNSIGNED;
      errors    = 0;
    endfunction

    // Strict "a goes ahead of b" under the current compare mode.
    function bit goes_ahead(logic [stq_pkg::KEY_W-1:0] a, logic [stq_pkg::KEY_W-1:0] b);
      logic [stq_pkg::KEY_W-1:0] gap;
      gap = a - b;
      if (wrap_mode) return gap[stq_pkg::KEY_W-1];
      return a < b;
    endfunction

    // Apply one accepted command to the shadow and queue the reply it owes.
    function void note_command(logic [stq_pkg::OP_W-1:0] op,
                               logic [stq_pkg::TASK_W-1:0] tnum,
                               logic [stq_pkg::KEY_W-1:0] key);
      queue_reply_t reply;
      queued_task_t ent;
      int           pos;
      int           i;
      bit           hit;
      reply.status      = stq_pkg::ST_OK;
      reply.head_task   = '0;
      reply.head_value  = '0;
      hit               = 1'b0;
      case (op)
        stq_pkg::OP_INS_SORTED, stq_pkg::OP_INS_TAIL: begin
          if (shadow.size() >= stq_pkg::MAX_TASKS) begin
            reply.status = stq_pkg::ST_FULL;
          end else begin
            pos = shadow.size();
            // ties land behind the existing equal keys
            if (op == stq_pkg::OP_INS_SORTED)
              for (i = 0; i < shadow.size() && !hit; i++)
                if (goes_ahead(key, shadow[i].key)) begin
                  pos = i;
                  hit = 1'b1;
                end
            ent.task_num = tnum;
            ent.key      = key;
            shadow.insert(pos, ent);
          end
        end
        stq_pkg::OP_REMOVE: begin
          reply.status = stq_pkg::ST_NOT_FOUND;
          for (i = 0; i < shadow.size() && !hit; i++)
            if (shadow[i].task_num == tnum) begin
              shadow.delete(i);
              reply.status = stq_pkg::ST_OK;
              hit = 1'b1;
            end
        end
        stq_pkg::OP_POP, stq_pkg::OP_PEEK: begin
          if (shadow.size() == 0) begin
            reply.status = stq_pkg::ST_EMPTY;
          end else begin
            reply.head_task  = shadow[0].task_num;
            reply.head_value = shadow[0].key;
            if (op == stq_pkg::OP_POP) void'(shadow.pop_front());
          end
        end
        default: ;
      endcase
      reply.entry_count = stq_pkg::CNT_W'(shadow.size());
      awaited.push_back(reply);
    endfunction

    function void flag_field(string field, logic [stq_pkg::KEY_W-1:0] want,
                             logic [stq_pkg::KEY_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                 $time, field, want, got);
      end
    endfunction

    function void check_result(queue_reply_t got);
      queue_reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, expected none, %s %0d task %0d key %0h count %0d",
                 $time, "actual status", got.status, got.head_task, got.head_value,
                 got.entry_count);
      end else begin
        want = awaited.pop_front();
        flag_field("status", stq_pkg::KEY_W'(want.status), stq_pkg::KEY_W'(got.status));
        flag_field("head_task", stq_pkg::KEY_W'(want.head_task),
                   stq_pkg::KEY_W'(got.head_task));
        flag_field("head_value", want.head_value, got.head_value);
        flag_field("entry_count", stq_pkg::KEY_W'(want.entry_count),
                   stq_pkg::KEY_W'(got.entry_count));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  stq_in_if  in_ch();
  stq_out_if out_ch();

  sorted_task_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sorted_queue_checker checker_h;

  // Percent chance per cycle that the sender holds off / the receiver stalls.
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  // 4 ns clock.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: ready is redrawn every falling edge.
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Everything is sampled at the rising edge, before the block's flops update.
  // A config write lands in the shadow at the same edge it lands in the block;
  // results are checked before the beat accepted on the same edge is noted,
  // which cannot matter since a beat's result is registered and never comes out on the edge that takes the beat.
  always @(posedge clk) begin
    queue_reply_t got;
    if (rst_n) begin
      if (cfg_we) checker_h.wrap_mode = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.status      = out_ch.status;
        got.head_task   = out_ch.head_task;
        got.head_value  = out_ch.head_value;
        got.entry_count = out_ch.entry_count;
        checker_h.check_result(got);
      end
      if (in_ch.valid && in_ch.ready)
        checker_h.note_command(in_ch.opcode, in_ch.task_number, in_ch.sort_value);
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Drive one beat: random hold-off first, then hold valid until taken.
  // Called and returns at a falling edge; valid stays high into the next
  // beat unless that beat decides to hold off.
  task automatic send_command(input logic [stq_pkg::OP_W-1:0] op,
                              input logic [stq_pkg::TASK_W-1:0] tnum,
                              input logic [stq_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.opcode      = op;
    in_ch.task_number = tnum;
    in_ch.sort_value  = key;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop sending and wait for every owed result to come back.
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (checker_h.awaited.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Mode change only with nothing in flight.
  task automatic set_compare_mode(input logic mode);
    drain_results();
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [stq_pkg::TASK_W-1:0] pick_task();
    return stq_pkg::TASK_W'($urandom_range(15));
  endfunction

  // Keys: clustered small values for ties, values around the sign boundary
  // and the top of the range for wraparound order, reuse of queued keys,
  // and full-range noise.
  function automatic logic [stq_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(15);
    if (r < 45) return KEY_SIGN_BIT + $urandom_range(7) - 4;
    if (r < 55) return KEY_MAX - $urandom_range(7);
    if (r < 65 && checker_h.shadow.size() != 0)
      return checker_h.shadow[$urandom_range(checker_h.shadow.size() - 1)].key;
    return $urandom;
  endfunction

  // Mostly names a task that is queued, so removes actually hit.
  function automatic logic [stq_pkg::TASK_W-1:0] pick_victim();
    if (checker_h.shadow.size() != 0 && $urandom_range(99) < 80)
      return checker_h.shadow[$urandom_range(checker_h.shadow.size() - 1)].task_num;
    return pick_task();
  endfunction

  task automatic send_random_command();
    int r;
    r = $urandom_range(99);
    if (r < 35)      send_command(stq_pkg::OP_INS_SORTED, pick_task(), pick_key());
    else if (r < 45) send_command(stq_pkg::OP_INS_TAIL, pick_task(), pick_key());
    else if (r < 65) send_command(stq_pkg::OP_REMOVE, pick_victim(), $urandom);
    else if (r < 83) send_command(stq_pkg::OP_POP, pick_task(), $urandom);
    else if (r < 93) send_command(stq_pkg::OP_PEEK, pick_task(), $urandom);
    else             send_command(stq_pkg::OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)),
                                  pick_task(), $urandom);
  endtask

  // A stretch of random traffic. Besides single commands it fills the queue
  // past full, empties it past empty, and now and then holds off until all
  // results are back.
  task automatic run_random(input int beats);
    int sent;
    int r;
    int extra;
    sent = 0;
    while (sent < beats) begin
      r = $urandom_range(99);
      if (r < 5) begin
        extra = $urandom_range(2, 1);
        while (checker_h.shadow.size() < stq_pkg::MAX_TASKS || extra-- > 0) begin
          send_command($urandom_range(99) < 80 ? stq_pkg::OP_INS_SORTED
                                               : stq_pkg::OP_INS_TAIL,
                       pick_task(), pick_key());
          sent++;
        end
      end else if (r < 10) begin
        while (checker_h.shadow.size() != 0) begin
          send_command(stq_pkg::OP_POP, pick_task(), $urandom);
          sent++;
        end
        send_command($urandom_range(1) ? stq_pkg::OP_POP : stq_pkg::OP_PEEK,
                     pick_task(), $urandom);
        sent++;
      end else if (r < 12) begin
        drain_results();
      end else begin
        send_random_command();
        sent++;
      end
    end
  endtask

  initial begin
    checker_h         = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = MODE_UNSIGNED;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = stq_pkg::OP_INS_SORTED;
    in_ch.task_number = '0;
    in_ch.sort_value  = '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed, unsigned order straight out of reset.
    send_command(stq_pkg::OP_PEEK, '0, '0);                  // peek on empty
    send_command(stq_pkg::OP_POP, '0, '0);                   // pop on empty
    send_command(stq_pkg::OP_REMOVE, '0, '0);                // remove from empty
    send_command(stq_pkg::OP_INS_SORTED, 4'd15, KEY_MAX);
    send_command(stq_pkg::OP_INS_SORTED, 4'd0, '0);
    send_command(stq_pkg::OP_INS_SORTED, 4'd3, 32'd100);
    send_command(stq_pkg::OP_INS_SORTED, 4'd4, 32'd100);     // equal key goes behind
    send_command(stq_pkg::OP_INS_TAIL, 4'd5, 32'd1);         // tail ignores order
    send_command(stq_pkg::OP_INS_SORTED, 4'd3, 32'd50);      // same task queued twice
    send_command(stq_pkg::OP_REMOVE, 4'd9, '0);              // absent task
    send_command(stq_pkg::OP_REMOVE, 4'd3, '0);              // takes the first task 3
    send_command(stq_pkg::OP_PEEK, '0, '0);
    send_command(OP_SPARE_LO, 4'd6, KEY_MAX);                // no-op opcodes
    send_command(OP_SPARE_HI, 4'd6, KEY_MAX);
    send_command(stq_pkg::OP_POP, '0, '0);

    // Directed, wraparound order around the sign boundary.
    set_compare_mode(MODE_WRAP);
    send_command(stq_pkg::OP_INS_SORTED, 4'd6, KEY_SIGN_BIT - 1);
    send_command(stq_pkg::OP_INS_SORTED, 4'd7, KEY_SIGN_BIT);
    send_command(stq_pkg::OP_INS_SORTED, 4'd8, '0);
    send_command(stq_pkg::OP_INS_SORTED, 4'd10, KEY_MAX);
    send_command(stq_pkg::OP_POP, '0, '0);
    send_command(stq_pkg::OP_PEEK, '0, '0);

    // Random: receiver-heavy stalling, then sender-heavy idling, then none at all;
    // each with both compare modes.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 27 : 0;
      set_compare_mode(MODE_UNSIGNED);
      run_random(BEATS_PER_STRETCH);
      set_compare_mode(MODE_WRAP);
      run_random(BEATS_PER_STRETCH);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (checker_h.errors == 0 && checker_h.awaited.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
